// ===== rtl/wss_pkg.sv =====
// Shared types, constants and helpers for the weighted sigmoid score block.
package wss_pkg;

  localparam int CHAN_W  = 32;
  localparam int REG_W   = 20;
  localparam int UNIT_W  = 17;
  localparam int PROD_W  = UNIT_W + REG_W;
  localparam int SUM_W   = REG_W + 2;
  localparam int Z_W     = SUM_W + 1;
  localparam int DIV_W   = 20;
  localparam int QUO_W   = 15;
  localparam int SCORE_W = 16;

  localparam logic [UNIT_W-1:0] ONE_Q16   = 17'd65536;
  localparam logic [UNIT_W-1:0] HALF_Q16  = 17'd32768;
  localparam logic [Z_W-1:0]    SAT_LIMIT = 23'd786432;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 16'd65535;

  localparam logic [REG_W-1:0] RST_WEIGHT_COND  = 20'd131072;
  localparam logic [REG_W-1:0] RST_WEIGHT_VAR   = 20'd163840;
  localparam logic [REG_W-1:0] RST_WEIGHT_THERM = 20'd196608;
  localparam logic [REG_W-1:0] RST_BIAS         = 20'd196608;

  localparam logic [1:0] REG_WEIGHT_COND  = 2'd0;
  localparam logic [1:0] REG_WEIGHT_VAR   = 2'd1;
  localparam logic [1:0] REG_WEIGHT_THERM = 2'd2;
  localparam logic [1:0] REG_BIAS         = 2'd3;

  typedef struct packed {
    logic [REG_W-1:0] w_cond;
    logic [REG_W-1:0] w_var;
    logic [REG_W-1:0] w_therm;
    logic [REG_W-1:0] bias;
  } coef_t;

  // One slot of the divider chain.
  typedef struct packed {
    logic             valid;
    logic             neg;
    logic             sat_lo;
    logic             sat_hi;
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } cell_t;

  function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [CHAN_W-1:0] v);
    logic [UNIT_W-1:0] r;
    if (v[CHAN_W-1]) begin
      r = '0;
    end else if (v > $signed({15'd0, ONE_Q16})) begin
      r = ONE_Q16;
    end else begin
      r = v[UNIT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/wss_front.sv =====
// Front end: clamp, weight multiply, sum, bias and divider setup.
module wss_front
  import wss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     take,
  input  logic signed [CHAN_W-1:0] chan_cond,
  input  logic signed [CHAN_W-1:0] chan_var,
  input  logic signed [CHAN_W-1:0] chan_therm,
  input  coef_t                    coef,
  output cell_t                    head
);

  logic [UNIT_W-1:0] g, v, vinv, t;
  logic [PROD_W-1:0] prod_g, prod_v, prod_t;
  logic [REG_W-1:0]  p_g_r, p_v_r, p_t_r;
  logic              s1_valid_r;

  logic [SUM_W-1:0]       sum;
  logic signed [Z_W-1:0]  z;
  logic [Z_W-1:0]         mag_full;
  logic                   sat_lo, sat_hi;
  cell_t                  head_nxt, head_r;

  always_comb begin
    g      = clamp_unit(chan_cond);
    v      = clamp_unit(chan_var);
    t      = clamp_unit(chan_therm);
    vinv   = ONE_Q16 - v;
    prod_g = PROD_W'(g) * PROD_W'(coef.w_cond);
    prod_v = PROD_W'(vinv) * PROD_W'(coef.w_var);
    prod_t = PROD_W'(t) * PROD_W'(coef.w_therm);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= take;
    end
    p_g_r <= prod_g[PROD_W-2:16];
    p_v_r <= prod_v[PROD_W-2:16];
    p_t_r <= prod_t[PROD_W-2:16];
  end

  always_comb begin
    sum      = SUM_W'(p_g_r) + SUM_W'(p_v_r) + SUM_W'(p_t_r);
    z        = $signed({1'b0, sum}) - $signed({3'b000, coef.bias});
    sat_lo   = (z <= -$signed(SAT_LIMIT));
    sat_hi   = (z >= $signed(SAT_LIMIT));
    mag_full = z[Z_W-1] ? Z_W'(-z) : Z_W'(z);
    head_nxt.valid  = s1_valid_r;
    head_nxt.neg    = z[Z_W-1];
    head_nxt.sat_lo = sat_lo;
    head_nxt.sat_hi = sat_hi;
    head_nxt.rem    = (sat_lo || sat_hi) ? '0 : mag_full[DIV_W-1:0];
    head_nxt.den    = DIV_W'(ONE_Q16) + head_nxt.rem;
    head_nxt.quo    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.valid <= 1'b0;
    end else begin
      head_r.valid <= head_nxt.valid;
    end
    head_r.neg    <= head_nxt.neg;
    head_r.sat_lo <= head_nxt.sat_lo;
    head_r.sat_hi <= head_nxt.sat_hi;
    head_r.rem    <= head_nxt.rem;
    head_r.den    <= head_nxt.den;
    head_r.quo    <= head_nxt.quo;
  end

  assign head = head_r;

endmodule

// ===== rtl/wss_div_cell.sv =====
// One restoring-division cell: produce one quotient bit and pass the item on.
module wss_div_cell
  import wss_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cell_t prev,
  output cell_t next
);

  logic [DIV_W:0]   shifted;
  logic [DIV_W+1:0] diff;
  logic             fits;
  cell_t            next_nxt, next_r;

  always_comb begin
    shifted  = {prev.rem, 1'b0};
    diff     = {1'b0, shifted} - {2'b00, prev.den};
    fits     = !diff[DIV_W+1];
    next_nxt = prev;
    if (fits) begin
      next_nxt.rem = diff[DIV_W-1:0];
      next_nxt.quo = {prev.quo[QUO_W-2:0], 1'b1};
    end else begin
      next_nxt.rem = shifted[DIV_W-1:0];
      next_nxt.quo = {prev.quo[QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_r.valid <= 1'b0;
    end else begin
      next_r.valid <= next_nxt.valid;
    end
    next_r.neg    <= next_nxt.neg;
    next_r.sat_lo <= next_nxt.sat_lo;
    next_r.sat_hi <= next_nxt.sat_hi;
    next_r.rem    <= next_nxt.rem;
    next_r.den    <= next_nxt.den;
    next_r.quo    <= next_nxt.quo;
  end

  assign next = next_r;

endmodule

// ===== rtl/wss_post.sv =====
// Back end: sign and saturate the sigmoid, scale to 16 bits, register result.
module wss_post
  import wss_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cell_t              tail,
  output logic               res_valid,
  output logic [SCORE_W-1:0] res_score
);

  logic [UNIT_W-1:0]  s;
  logic [UNIT_W+15:0] scaled;
  logic [UNIT_W-1:0]  rounded;
  logic [SCORE_W-1:0] score_nxt, score_r;
  logic               valid_r;

  always_comb begin
    priority if (tail.sat_lo) begin
      s = '0;
    end else if (tail.sat_hi) begin
      s = ONE_Q16;
    end else if (tail.neg) begin
      s = HALF_Q16 - UNIT_W'(tail.quo);
    end else begin
      s = HALF_Q16 + UNIT_W'(tail.quo);
    end
    // s*65535 + 32768 written as (s<<16) - s + 32768
    scaled  = {s, 16'd0} - (UNIT_W+16)'(s) + (UNIT_W+16)'(HALF_Q16);
    rounded = scaled[UNIT_W+15:16];
    score_nxt = rounded[UNIT_W-1] ? SCORE_MAX : rounded[SCORE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= tail.valid;
    end
    score_r <= score_nxt;
  end

  assign res_valid = valid_r;
  assign res_score = score_r;

endmodule

// ===== rtl/weighted_sigmoid_score.sv =====
// Top level of the weighted rational-sigmoid score pipeline.
// Throughput: one item per cycle while busy is low; fifteen divider cells each retire one quotient bit.
// Results appear for one cycle only; the receiver cannot stall the pipe.
// Reset (rst_n low, synchronous): flush the pipeline, restore default weights and bias;
// busy stays high during reset and in the cycle after it.
module weighted_sigmoid_score
  import wss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // input item channel
  input  logic                     start,
  output logic                     busy,
  input  logic signed [CHAN_W-1:0] in_chan_conductance,
  input  logic signed [CHAN_W-1:0] in_chan_variability,
  input  logic signed [CHAN_W-1:0] in_chan_thermal,
  // result channel
  output logic                     out_valid,
  output logic [SCORE_W-1:0]       out_score,
  // configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [REG_W-1:0]         cfg_data
);

  logic  busy_r;
  logic  take;
  coef_t coef_r;
  cell_t chain [0:QUO_W];

  // Hold off items while reset is applied and in the cycle after it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r | !rst_n;
  assign take = start && !busy;

  // Configuration registers: always ready; the writer must change them only while idle; the block does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.w_cond  <= RST_WEIGHT_COND;
      coef_r.w_var   <= RST_WEIGHT_VAR;
      coef_r.w_therm <= RST_WEIGHT_THERM;
      coef_r.bias    <= RST_BIAS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WEIGHT_COND:  coef_r.w_cond  <= cfg_data;
        REG_WEIGHT_VAR:   coef_r.w_var   <= cfg_data;
        REG_WEIGHT_THERM: coef_r.w_therm <= cfg_data;
        REG_BIAS:         coef_r.bias    <= cfg_data;
      endcase
    end
  end

  // Stages 1-2: clamp, multiply, sum, subtract bias, set up |z| / (1 + |z|).
  wss_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .chan_cond  (in_chan_conductance),
    .chan_var   (in_chan_variability),
    .chan_therm (in_chan_thermal),
    .coef       (coef_r),
    .head       (chain[0])
  );

  // Divider chain: each cell shifts the remainder, tries the subtract, and
  // appends one quotient bit, most significant first.
  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    wss_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .prev  (chain[i]),
      .next  (chain[i+1])
    );
  end

  // Final stage: apply sign and saturation, scale, drive the result strobe.
  wss_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .tail      (chain[QUO_W]),
    .res_valid (out_valid),
    .res_score (out_score)
  );

endmodule

// ===== rtl/wss_checker.sv =====
// Port-level checker for the weighted sigmoid score block, with its bind.
module wss_checker
  import wss_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  a_reset_clears_strobe: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  a_busy_in_reset: assert property (@(posedge clk) !rst_n |-> busy)
    else $error("busy low while reset is applied");

  a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##18 out_valid)
    else $error("accepted item produced no result after 18 cycles");

  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 18))
    else $error("result strobe without an item taken 18 cycles before");

endmodule

bind weighted_sigmoid_score wss_checker u_wss_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for weighted_sigmoid_score: random sample bursts vs. a predictor.
module tb;
  import wss_pkg::*;

  localparam int DRAIN_CYCLES   = 30;    // pipe is 18 deep; leave margin
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake of any kind
  localparam int REPORT_LIMIT   = 10;

  typedef struct {
    logic signed [CHAN_W-1:0] conductance;
    logic signed [CHAN_W-1:0] variability;
    logic signed [CHAN_W-1:0] thermal;
  } sample_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [CHAN_W-1:0] in_chan_conductance = '0;
  logic signed [CHAN_W-1:0] in_chan_variability = '0;
  logic signed [CHAN_W-1:0] in_chan_thermal = '0;
  logic                     out_valid;
  logic [SCORE_W-1:0]       out_score;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [1:0]               cfg_index = REG_WEIGHT_COND;
  logic [REG_W-1:0]         cfg_data = '0;

  // Samples waiting for the driver, and scores waiting for the monitor.
  sample_t            sample_fifo[$];
  logic [SCORE_W-1:0] score_fifo[$];
  sample_t            cur_sample;

  // Shadow of the coefficient registers; starts at the reset values.
  coef_t coef_shadow = '{w_cond: RST_WEIGHT_COND, w_var: RST_WEIGHT_VAR,
                         w_therm: RST_WEIGHT_THERM, bias: RST_BIAS};

  int unsigned n_queued    = 0;
  int unsigned n_accepted  = 0;
  int unsigned n_mismatch  = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 1;
  int unsigned gap_left    = 0;

  weighted_sigmoid_score u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_chan_conductance (in_chan_conductance),
    .in_chan_variability (in_chan_variability),
    .in_chan_thermal     (in_chan_thermal),
    .out_valid           (out_valid),
    .out_score           (out_score),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Score predictor
  // ---------------------------------------------------------------------------

  // Clip a signed Q16.16 channel to [0, 1.0].
  function automatic logic [UNIT_W-1:0] unit_clip(input logic signed [CHAN_W-1:0] raw);
    if (raw < 0) return '0;
    if (raw > 65536) return ONE_Q16;
    return raw[UNIT_W-1:0];
  endfunction

  function automatic logic [SCORE_W-1:0] sigmoid_score(input sample_t smp, input coef_t c);
    logic [UNIT_W-1:0] g, v, t, vinv;
    longint sum, z, mag, q, s, sc;
    g    = unit_clip(smp.conductance);
    v    = unit_clip(smp.variability);
    t    = unit_clip(smp.thermal);
    vinv = ONE_Q16 - v;
    sum  = ((longint'(g) * c.w_cond) >> 16)
         + ((longint'(vinv) * c.w_var) >> 16)
         + ((longint'(t) * c.w_therm) >> 16);
    z    = sum - longint'(c.bias);
    // Saturate at +/-12.0, otherwise 0.5 + z/(2(1+|z|)), quotient toward zero.
    if (z <= -786432) begin
      s = 0;
    end else if (z >= 786432) begin
      s = 65536;
    end else begin
      mag = (z < 0) ? -z : z;
      q   = (z * 32768) / (65536 + mag);
      s   = 32768 + q;
      if (s < 0) s = 0;
      if (s > 65536) s = 65536;
    end
    sc = (s * 65535 + 32768) >> 16;
    if (sc > 65535) sc = 65535;
    return sc[SCORE_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pull samples from the queue in bursts, hold each until taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    if (!rst_n) begin
      start      <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else begin
      // Item taken at this edge: predict its score with the current coefficients.
      if (start && !busy) begin
        score_fifo.push_back(sigmoid_score(cur_sample, coef_shadow));
        n_accepted++;
      end
      // Hold the item while busy; otherwise advance.
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (sample_fifo.size() != 0) begin
          cur_sample = sample_fifo.pop_front();
          in_chan_conductance <= cur_sample.conductance;
          in_chan_variability <= cur_sample.variability;
          in_chan_thermal     <= cur_sample.thermal;
          start <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            // Long bursts give stretches with no idling at all.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 12);
            gap_left   = $urandom_range(1, 12);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed score must match the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    logic [SCORE_W-1:0] want;
    if (rst_n && out_valid) begin
      if (score_fifo.size() == 0) begin
        if (n_mismatch < REPORT_LIMIT)
          $display("tb: unexpected score %0d with nothing pending", out_score);
        n_mismatch++;
      end else begin
        want = score_fifo.pop_front();
        if (out_score !== want) begin
          if (n_mismatch < REPORT_LIMIT)
            $display("tb: score mismatch: expected %0d, got %0d", want, out_score);
          n_mismatch++;
        end
      end
    end
  end

  // Watchdog: drop the run if nothing moves for too long. A strobe only counts
  // while a score is pending, so a stuck strobe cannot keep the run alive.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (start && !busy) || (out_valid && score_fifo.size() != 0) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic logic signed [CHAN_W-1:0] random_channel();
    logic signed [CHAN_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 65536);
      4: begin
        case ($urandom_range(0, 3))
          0: v = 0;
          1: v = 65536;
          2: v = -1;
          default: v = 65537;
        endcase
      end
      5, 6: v = $urandom;
      7: v = -$signed({1'b0, 31'($urandom_range(1, 100000))});
      8: v = 65536 + $urandom_range(1, 100000);
      default: v = 65536 - $urandom_range(0, 4);
    endcase
    return v;
  endfunction

  task automatic add_sample(input logic signed [CHAN_W-1:0] c,
                            input logic signed [CHAN_W-1:0] v,
                            input logic signed [CHAN_W-1:0] t);
    sample_t smp;
    smp.conductance = c;
    smp.variability = v;
    smp.thermal     = t;
    sample_fifo.push_back(smp);
    n_queued++;
  endtask

  task automatic add_random_samples(input int count);
    for (int i = 0; i < count; i++)
      add_sample(random_channel(), random_channel(), random_channel());
  endtask

  // Poll off the active edge so the counters are settled, then let the pipe empty.
  task automatic wait_drained();
    do @(negedge clk); while (n_accepted != n_queued || score_fifo.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Call right after a rising edge; leaves valid high for a following write.
  task automatic write_reg(input logic [1:0] idx, input logic [REG_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WEIGHT_COND:  coef_shadow.w_cond  = val;
      REG_WEIGHT_VAR:   coef_shadow.w_var   = val;
      REG_WEIGHT_THERM: coef_shadow.w_therm = val;
      REG_BIAS:         coef_shadow.bias    = val;
      default: ;
    endcase
  endtask

  task automatic load_coefs(input coef_t c);
    write_reg(REG_WEIGHT_COND,  c.w_cond);
    write_reg(REG_WEIGHT_VAR,   c.w_var);
    write_reg(REG_WEIGHT_THERM, c.w_therm);
    write_reg(REG_BIAS,         c.bias);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_coefs(output coef_t c);
    c.w_cond  = $urandom_range(0, 1048575);
    c.w_var   = $urandom_range(0, 1048575);
    c.w_therm = $urandom_range(0, 1048575);
    c.bias    = $urandom_range(0, 1048575);
  endtask

  initial begin : stimulus
    coef_t c;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset coefficients: channel extremes, out-of-range and sign-bit patterns.
    add_sample(0, 0, 0);
    add_sample(65536, 65536, 65536);
    add_sample(0, 65536, 0);               // lowest z for these weights
    add_sample(65536, 0, 65536);           // highest z for these weights
    add_sample(-1, -1, -1);
    add_sample(65537, 65537, 65537);
    add_sample(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    add_sample(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    add_sample(32768, 32768, 32768);
    add_sample(1, 65535, 1);
    add_sample(32'sh0001_ffff, -65536, 32'sh0001_0000);
    add_sample(32'shffff_0000, 32'sh0000_ffff, 32'sh5555_aaaa);
    add_random_samples(200);

    // z lands exactly on +12.0 at full conductance, just below one step lower.
    wait_drained();
    load_coefs('{w_cond: 20'd786432, w_var: 20'd0, w_therm: 20'd0, bias: 20'd0});
    add_sample(65536, 0, 0);
    add_sample(65535, 0, 0);
    add_sample(0, 0, 0);
    add_random_samples(140);

    // z lands exactly on -12.0 with no conductance, one step above with 1 LSB.
    wait_drained();
    load_coefs('{w_cond: 20'd65536, w_var: 20'd0, w_therm: 20'd0, bias: 20'd786432});
    add_sample(0, 0, 0);
    add_sample(1, 0, 0);
    add_sample(65536, 0, 0);
    add_random_samples(140);

    // Register extremes: largest positive z, most negative z, all zero, all full.
    wait_drained();
    load_coefs('{w_cond: 20'hfffff, w_var: 20'hfffff, w_therm: 20'hfffff, bias: 20'd0});
    add_sample(65536, 0, 65536);
    add_random_samples(140);

    wait_drained();
    load_coefs('{w_cond: 20'd0, w_var: 20'd0, w_therm: 20'd0, bias: 20'hfffff});
    add_random_samples(140);

    wait_drained();
    load_coefs('{w_cond: 20'd0, w_var: 20'd0, w_therm: 20'd0, bias: 20'd0});
    add_random_samples(140);

    wait_drained();
    load_coefs('{w_cond: 20'hfffff, w_var: 20'hfffff, w_therm: 20'hfffff, bias: 20'hfffff});
    add_random_samples(140);

    wait_drained();
    load_coefs('{w_cond: 20'd0, w_var: 20'hfffff, w_therm: 20'd0, bias: 20'd524288});
    add_random_samples(140);

    // Moderate weights that keep z inside the curved part of the sigmoid.
    wait_drained();
    load_coefs('{w_cond: 20'd262144, w_var: 20'd196608, w_therm: 20'd327680,
                 bias: 20'd393216});
    add_random_samples(140);

    for (int k = 0; k < 4; k++) begin
      wait_drained();
      random_coefs(c);
      load_coefs(c);
      add_random_samples(140);
    end

    // Back to the reset coefficients, written explicitly.
    wait_drained();
    load_coefs('{w_cond: RST_WEIGHT_COND, w_var: RST_WEIGHT_VAR,
                 w_therm: RST_WEIGHT_THERM, bias: RST_BIAS});
    add_random_samples(120);

    wait_drained();
    if (n_mismatch == 0 && score_fifo.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
